@@ src/dic_pkg.sv @@
// shared types and sizing constants for the distinct identifier counter
// no dependencies
package dic_pkg;

  localparam int MAX_NAMES    = 128;
  localparam int MAX_NAME_LEN = 32;

  localparam int LW   = $clog2(MAX_NAME_LEN + 1);
  localparam int LIW  = $clog2(MAX_NAME_LEN);
  localparam int EW   = $clog2(MAX_NAMES + 1);
  localparam int NIW  = $clog2(MAX_NAMES);
  localparam int CAW  = $clog2(MAX_NAMES * MAX_NAME_LEN);
  localparam int QDEPTH = 4;
  localparam int QPW  = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] char_byte;
    logic       chunk_last;
  } in_t;

  typedef struct packed {
    logic [7:0]  chunk_distinct;
    logic [31:0] total_distinct;
    logic        table_full;
    logic        name_truncated;
  } out_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       add;
    logic       start;
    logic       fin;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

@@ src/dic_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module dic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/dic_front.sv @@
// front end: classifies bytes and tracks whether an identifier is open
// depends on dic_pkg
module dic_front import dic_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  in_t  item,
  input  logic q_full,
  output logic full,
  output logic q_push,
  output cmd_t q_cmd
);

  logic in_name;
  logic alpha, digit, add, fin;
  logic [7:0] lower;

  always_comb begin
    lower = item.char_byte | 8'h20;
    alpha = (lower >= 8'h61) && (lower <= 8'h7a);
    digit = (item.char_byte >= 8'h30) && (item.char_byte <= 8'h39);
    add   = in_name ? (alpha || digit) : alpha;
    // open name ends on a separator, or at chunk end once this byte is taken
    fin   = (in_name && !(alpha || digit)) || (item.chunk_last && add);
    q_cmd.ch    = item.char_byte;
    q_cmd.add   = add;
    q_cmd.start = !in_name && alpha;
    q_cmd.fin   = fin;
    q_cmd.last  = item.chunk_last;
  end

  assign full   = q_full;
  assign q_push = push && !q_full && (add || fin || item.chunk_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_name <= 1'b0;
    end else if (push && !q_full) begin
      in_name <= add && !fin;
    end
  end

endmodule

@@ src/dic_cmdq.sv @@
// short command queue between front and back
// depends on dic_pkg
module dic_cmdq import dic_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  cmd_t   wdata,
  input  logic   rd,
  output cmd_t   rdata,
  output qstat_t stat
);

  cmd_t           slots [QDEPTH];
  logic [QPW-1:0] wptr, rptr;
  logic [QPW:0]   count;

  assign stat.full  = (count == (QPW+1)'(QDEPTH));
  assign stat.empty = (count == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !stat.full) begin
        slots[wptr] <= wdata;
        wptr <= wptr + 1'b1;
      end
      if (rd && !stat.empty) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (QPW+1)'(wr && !stat.full) - (QPW+1)'(rd && !stat.empty);
    end
  end

endmodule

@@ src/dic_back.sv @@
// back end: collects names, searches and fills the table, emits chunk results
// depends on dic_pkg, dic_ram
module dic_back import dic_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  qstat_t q_stat,
  input  cmd_t   q_cmd,
  output logic   q_pop,
  input  logic   pop,
  output logic   empty,
  output out_t   result
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LRD  = 7'b0000010,
    S_LCHK = 7'b0000100,
    S_CRD  = 7'b0001000,
    S_CCHK = 7'b0010000,
    S_COPY = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state;
  logic [7:0]    cur_name [MAX_NAME_LEN];
  logic [LW-1:0] cur_len;
  logic [EW-1:0] entry_count, idx;
  logic [LIW-1:0] j;
  logic          last_pend, flag_full, flag_trunc, out_valid;
  logic [31:0]   total;

  logic [LW-1:0]  eff_len, len_q;
  logic [7:0]     chr_q;
  logic           chr_we, len_we, j_at_end, emit;
  logic [CAW-1:0] chr_waddr, chr_raddr;
  logic [NIW-1:0] len_raddr;
  logic [31:0]    cnt32;
  logic [32:0]    sum;

  assign q_pop    = (state == S_IDLE) && !q_stat.empty;
  assign eff_len  = q_cmd.start ? '0 : cur_len;
  assign j_at_end = (LW'(j) + LW'(1)) == cur_len;
  assign len_raddr = idx[NIW-1:0];
  assign chr_raddr = CAW'(idx[NIW-1:0]) * CAW'(MAX_NAME_LEN) + CAW'(j);
  assign chr_waddr = CAW'(entry_count[NIW-1:0]) * CAW'(MAX_NAME_LEN) + CAW'(j);
  assign chr_we   = (state == S_COPY);
  assign len_we   = (state == S_COPY) && j_at_end;
  assign cnt32    = 32'(entry_count);
  assign sum      = 33'(total) + 33'(cnt32);
  assign empty    = !out_valid;
  // result register is free or its transfer happens this cycle
  assign emit     = (state == S_EMIT) && (!out_valid || pop);

  dic_ram #(.WIDTH(8), .DEPTH(MAX_NAMES * MAX_NAME_LEN)) u_chars (
    .clk(clk), .we(chr_we), .waddr(chr_waddr), .wdata(cur_name[j]),
    .raddr(chr_raddr), .rdata(chr_q)
  );

  dic_ram #(.WIDTH(LW), .DEPTH(MAX_NAMES)) u_lens (
    .clk(clk), .we(len_we), .waddr(entry_count[NIW-1:0]), .wdata(cur_len),
    .raddr(len_raddr), .rdata(len_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur_len     <= '0;
      entry_count <= '0;
      idx         <= '0;
      j           <= '0;
      last_pend   <= 1'b0;
      flag_full   <= 1'b0;
      flag_trunc  <= 1'b0;
      out_valid   <= 1'b0;
      total       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            last_pend <= q_cmd.last;
            if (q_cmd.add) begin
              if (eff_len < LW'(MAX_NAME_LEN)) begin
                cur_name[eff_len[LIW-1:0]] <= q_cmd.ch;
                cur_len <= eff_len + LW'(1);
              end else begin
                cur_len    <= eff_len;
                flag_trunc <= 1'b1;
              end
            end
            if (q_cmd.fin) begin
              idx   <= '0;
              state <= S_LRD;
            end else if (q_cmd.last) begin
              state <= S_EMIT;
            end
          end
        end
        S_LRD: begin
          j <= '0;
          if (idx == entry_count) begin
            if (entry_count < EW'(MAX_NAMES)) begin
              state <= S_COPY;
            end else begin
              flag_full <= 1'b1;
              cur_len   <= '0;
              state     <= last_pend ? S_EMIT : S_IDLE;
            end
          end else begin
            state <= S_LCHK;
          end
        end
        S_LCHK: begin
          if (len_q == cur_len) begin
            state <= S_CRD;
          end else begin
            idx   <= idx + EW'(1);
            state <= S_LRD;
          end
        end
        S_CRD: begin
          state <= S_CCHK;
        end
        S_CCHK: begin
          if (chr_q != cur_name[j]) begin
            idx   <= idx + EW'(1);
            state <= S_LRD;
          end else if (j_at_end) begin
            // already in the table
            cur_len <= '0;
            state   <= last_pend ? S_EMIT : S_IDLE;
          end else begin
            j     <= j + LIW'(1);
            state <= S_CRD;
          end
        end
        S_COPY: begin
          if (j_at_end) begin
            entry_count <= entry_count + EW'(1);
            cur_len     <= '0;
            state       <= last_pend ? S_EMIT : S_IDLE;
          end else begin
            j <= j + LIW'(1);
          end
        end
        S_EMIT: begin
          if (emit) begin
            result.chunk_distinct <= (cnt32 > 32'd255) ? 8'hff : cnt32[7:0];
            result.total_distinct <= sum[32] ? 32'hffff_ffff : sum[31:0];
            result.table_full     <= flag_full;
            result.name_truncated <= flag_trunc;
            total       <= sum[32] ? 32'hffff_ffff : sum[31:0];
            entry_count <= '0;
            flag_full   <= 1'b0;
            flag_trunc  <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/distinct_identifier_counter.sv @@
// top level of the distinct identifier counter
// depends on dic_pkg, dic_front, dic_cmdq, dic_back
//
// usage:
//   input side is a queue: drive item and raise push; a transfer happens at a
//   clock edge with push high and full low. item.chunk_last marks a chunk end.
//   result side is a queue: result is valid while empty is low and is taken
//   at an edge with pop high. one result per chunk.
// flow:
//   the front takes a byte per cycle, while the queue is not full, into a
//   four-entry command queue. the back takes one command at a time in its
//   idle state, and at each identifier end walks the table: it reads and
//   checks the stored length of each entry, compares the characters of one
//   matching in length until a mismatch or its end, and copies each character
//   of a new name. the walk over the table rams limits the sustained rate. a
//   chunk result is registered in the emit state after its last command.
// reset:
//   synchronous rst clears counts, flags, running total and the queues; the
//   table contents need no clearing.
// stall:
//   a waiting result holds while pop is low; the back stops before the next
//   result and the command queue then fills, raising full.
module distinct_identifier_counter import dic_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  in_t  item,
  output logic full,
  input  logic pop,
  output logic empty,
  output out_t result
);

  logic   q_push, q_pop;
  cmd_t   q_wcmd, q_rcmd;
  qstat_t q_stat;

  dic_front u_front (
    .clk(clk), .rst(rst), .push(push), .item(item), .q_full(q_stat.full),
    .full(full), .q_push(q_push), .q_cmd(q_wcmd)
  );

  dic_cmdq u_cmdq (
    .clk(clk), .rst(rst), .wr(q_push), .wdata(q_wcmd), .rd(q_pop),
    .rdata(q_rcmd), .stat(q_stat)
  );

  dic_back u_back (
    .clk(clk), .rst(rst), .q_stat(q_stat), .q_cmd(q_rcmd), .q_pop(q_pop),
    .pop(pop), .empty(empty), .result(result)
  );

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty) else $error("command pop on empty queue");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full) else $error("command push on full queue");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result))) else $error("result lost");
`endif

endmodule

@@ tb/sv/distinct_identifier_counter_tb.sv @@
// testbench for the distinct identifier counter: directed and random byte chunks
// depends on dic_pkg and distinct_identifier_counter; predicts results internally
`timescale 1ns / 100ps

module distinct_identifier_counter_tb;
  import dic_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  in_t  item = '0;
  logic full;
  logic pop = 1'b0;
  logic empty;
  out_t result;

  distinct_identifier_counter DUT (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full),
    .pop(pop), .empty(empty), .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  ident_tbl [MAX_NAMES][MAX_NAME_LEN];
  int          ident_len [MAX_NAMES];
  logic [7:0]  cur_ident [MAX_NAME_LEN];
  int          cur_len;
  bit          collecting;
  int          n_idents;
  logic [31:0] sum_distinct;
  bit          drop_flag;
  bit          trunc_flag;

  out_t chunk_results [$];
  int   err_count = 0;
  bit   quiet_mode = 1'b0;
  int   pop_idle_pct = 20;
  int   push_idle_pct = 20;

  function automatic bit is_alpha(logic [7:0] b);
    logic [7:0] lw;
    lw = b | 8'h20;
    return lw >= "a" && lw <= "z";
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic void append_char(logic [7:0] b);
    if (cur_len < MAX_NAME_LEN) begin
      cur_ident[cur_len] = b;
      cur_len++;
    end else begin
      trunc_flag = 1'b1;
    end
  endfunction

  function automatic void close_ident();
    bit same;
    for (int i = 0; i < n_idents; i++) begin
      if (ident_len[i] == cur_len) begin
        same = 1'b1;
        for (int j = 0; j < cur_len; j++)
          if (ident_tbl[i][j] != cur_ident[j]) same = 1'b0;
        if (same) begin
          collecting = 1'b0;
          cur_len = 0;
          return;
        end
      end
    end
    if (n_idents < MAX_NAMES) begin
      for (int j = 0; j < cur_len; j++) ident_tbl[n_idents][j] = cur_ident[j];
      ident_len[n_idents] = cur_len;
      n_idents++;
    end else begin
      drop_flag = 1'b1;
    end
    collecting = 1'b0;
    cur_len = 0;
  endfunction

  function automatic void predict_byte(in_t it);
    out_t r;
    if (collecting) begin
      if (is_alpha(it.char_byte) || is_digit(it.char_byte)) append_char(it.char_byte);
      else close_ident();
    end else if (is_alpha(it.char_byte)) begin
      collecting = 1'b1;
      cur_len = 0;
      append_char(it.char_byte);
    end
    if (!it.chunk_last) return;
    if (collecting) close_ident();
    if (n_idents > 32'hFFFF_FFFF - sum_distinct) sum_distinct = 32'hFFFF_FFFF;
    else sum_distinct = sum_distinct + n_idents;
    r.chunk_distinct = (n_idents > 255) ? 8'd255 : n_idents[7:0];
    r.total_distinct = sum_distinct;
    r.table_full     = drop_flag;
    r.name_truncated = trunc_flag;
    chunk_results.push_back(r);
    n_idents = 0;
    drop_flag = 1'b0;
    trunc_flag = 1'b0;
  endfunction

  // one byte transfer; push stays high if the next call follows at once
  task automatic send_byte(logic [7:0] b, bit last);
    in_t it;
    it.char_byte = b;
    it.chunk_last = last;
    if (!quiet_mode) begin
      while ($urandom_range(99) < push_idle_pct) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_byte(it);
  endtask

  task automatic send_text(string s, bit close_chunk);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], close_chunk && (i == s.len() - 1));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    push <= 1'b0;
    while (chunk_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && pop && !empty) begin
      if (chunk_results.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result %p", result);
      end else begin
        want = chunk_results.pop_front();
        if (result !== want) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected %p actual %p", want, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    pop <= quiet_mode ? 1'b1 : ($urandom_range(99) >= pop_idle_pct);
  end

  task automatic test_field_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);            // chunk with no identifiers
    send_text("A z Z a", 1'b1);
    send_text("9abc 0x1 Ab9", 1'b1);   // leading digits ignored
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_repeats_and_case();
    send_text("foo bar foo Foo FOO bar", 1'b1);
    // separators around letter bounds
    send_text("x", 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("x@x[x`x{x", 1'b1);
    send_text("tail", 1'b1);
  endtask

  task automatic test_truncation();
    string s;
    s = "";
    for (int i = 0; i < MAX_NAME_LEN + 5; i++) s = {s, "q"};
    send_text({s, " ", s.substr(0, MAX_NAME_LEN - 1)}, 1'b1);
    s = "";
    for (int i = 0; i < MAX_NAME_LEN; i++) s = {s, "r"};
    send_text(s, 1'b1);                // exactly full length, no flag
  endtask

  task automatic test_table_full();
    for (int i = 0; i < MAX_NAMES + 3; i++)
      send_text($sformatf("n%0d ", i), 1'b0);
    send_text("n0 n130", 1'b1);
  endtask

  task automatic test_paused_sender();
    send_text("p q r p", 1'b1);
    drain();
  endtask

  task automatic test_random_chunks(int n_bytes);
    int sent, len, ch;
    logic [7:0] b;
    sent = 0;
    while (sent < n_bytes) begin
      quiet_mode = (sent > n_bytes / 2 && sent < n_bytes / 2 + 150);
      len = ($urandom_range(9) == 0) ? $urandom_range(200, 60) : $urandom_range(30, 1);
      for (int i = 0; i < len; i++) begin
        ch = $urandom_range(99);
        if (ch < 8) b = 8'($urandom_range(255));
        else if (ch < 25) b = " ";
        else if (ch < 35) b = 8'("0" + $urandom_range(9));
        else if (ch < 40) b = 8'h00;
        else b = 8'("a" + $urandom_range(3) - ($urandom_range(1) ? 8'h20 : 8'h00));
        send_byte(b, i == len - 1);
        sent++;
      end
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    cur_len = 0; collecting = 0; n_idents = 0;
    sum_distinct = '0; drop_flag = 0; trunc_flag = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_repeats_and_case();
    test_truncation();
    test_table_full();
    test_paused_sender();
    test_random_chunks(900);
    drain();
    if (err_count == 0 && chunk_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
